// ----- rtl/isl_pkg.sv -----
// Shared constants, codes and types for the indexed shift list.
`default_nettype none

package isl_pkg;

    // Sizing of the list
    localparam int DEPTH         = 16;
    localparam int ELEMENT_WIDTH = 32;

    // Fixed field widths of the channels
    localparam int KIND_W   = 2;
    localparam int POS_W    = 4;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Derived internal widths
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef logic [ELEMENT_WIDTH-1:0] word_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_FIND   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic             read_en;
        logic             find_en;
        logic [CMP_W-1:0] pos;
        logic [CMP_W-1:0] count;
        word_t            value;
        word_t            mask;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/isl_if.sv -----
// Request and response channel interfaces of the indexed shift list.
`default_nettype none

interface isl_req_if;
    import isl_pkg::*;

    logic                 valid;
    logic                 ready;
    kind_t                kind;
    logic [POS_W-1:0]     position;
    logic [FIELD_W-1:0]   value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface isl_rsp_if;
    import isl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FIELD_W-1:0]   read_word;
    logic                 hit;
    logic [POS_W-1:0]     hit_position;
    status_t              status;
    logic [COUNT_W-1:0]   count;

    modport source (output valid, output read_word, output hit, output hit_position,
                    output status, output count, input ready);
    modport sink   (input valid, input read_word, input hit, input hit_position,
                    input status, input count, output ready);
endinterface

`default_nettype wire

// ----- rtl/indexed_shift_list_top.sv -----
// Top level of the indexed shift list: request decode, cell row and response register.
//
// Usage:
//   req carries one request per beat (kind, position, value); rsp returns exactly
//   one response beat per request (read_word, hit, hit_position, status, count).
//   A request is taken when req.valid and req.ready are both high. Insert and
//   erase shift every later word by one place in the same cycle, because each
//   cell loads from its left or right neighbour in parallel; read and find
//   select from the row through a first-match chain running along the cells.
//   The response is registered: it appears in the register after the edge
//   that takes the request. One request per cycle is taken while req.ready is high.
//   req.ready is high whenever the response register is empty or is being
//   drained, so a stalled receiver holds its beat and blocks new requests only
//   while that beat waits.
//   cfg_we/cfg_wdata write compare_mask, used by find; write it only while idle.
//   Reset empties the list (fill count zero), sets compare_mask to all ones and
//   clears the response valid flag. Word storage is not cleared: positions at or
//   above the count are never read.
`default_nettype none

module indexed_shift_list_top (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    isl_req_if.sink                       req,
    isl_rsp_if.source                     rsp,
    input  wire logic                     cfg_we,
    input  wire logic [isl_pkg::FIELD_W-1:0] cfg_wdata
);
    import isl_pkg::*;

    logic [FIELD_W-1:0] compare_mask_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] read_word_reg;
    logic               hit_reg;
    logic [POS_W-1:0]   hit_position_reg;
    status_t            status_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic               accept;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   count_ext;
    logic               is_full;
    status_t            status_next;
    cell_ctrl_t         ctrl;

    word_t              word_w  [DEPTH];
    logic               sel_w   [DEPTH];
    logic               found_w [DEPTH+1];

    word_t              sel_word;
    logic [IDX_W-1:0]   sel_idx;
    logic               hit_next;

    assign accept    = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;

    assign pos_ext   = CMP_W'(req.position);
    assign count_ext = CMP_W'(count_reg);
    assign is_full   = count_ext == CMP_W'(DEPTH);

    // Decode the request against the current fill count
    always_comb
    begin
        status_next = STATUS_OK;
        count_next  = count_reg;
        ctrl        = '0;
        ctrl.pos    = pos_ext;
        ctrl.count  = count_ext;
        ctrl.value  = ELEMENT_WIDTH'(req.value);
        ctrl.mask   = ELEMENT_WIDTH'(compare_mask_reg);
        case (req.kind)
            KIND_INSERT:
            begin
                if (pos_ext > count_ext)
                begin
                    status_next = STATUS_RANGE;
                end
                else if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    ctrl.shift_up = accept;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            KIND_ERASE:
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next = STATUS_RANGE;
                end
                else
                begin
                    ctrl.shift_down = accept;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            KIND_READ:
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next = STATUS_RANGE;
                end
                else
                begin
                    ctrl.read_en = 1'b1;
                end
            end
            KIND_FIND:
            begin
                ctrl.find_en = 1'b1;
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    // Row of cells with neighbour links and the first-match chain
    assign found_w[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        isl_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(g)),
            .ctrl       (ctrl),
            .left_word  (word_w[(g == 0) ? 0 : g - 1]),
            .right_word (word_w[(g == DEPTH - 1) ? g : g + 1]),
            .found_in   (found_w[g]),
            .word       (word_w[g]),
            .found_out  (found_w[g+1]),
            .sel        (sel_w[g])
        );
    end

    // Gather the selected word and its position; at most one cell is selected
    always_comb
    begin
        sel_word = '0;
        sel_idx  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel_w[i])
            begin
                sel_word = sel_word | word_w[i];
                sel_idx  = sel_idx | IDX_W'(i);
            end
        end
    end

    assign hit_next = ctrl.find_en && found_w[DEPTH];

    // Hold compare mask and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_mask_reg <= '1;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                compare_mask_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Response register: load on accept, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_word_reg    <= FIELD_W'(sel_word);
            hit_reg          <= hit_next;
            hit_position_reg <= hit_next ? POS_W'(sel_idx) : '0;
            status_reg       <= status_next;
            count_out_reg    <= COUNT_W'(count_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_word    = read_word_reg;
    assign rsp.hit          = hit_reg;
    assign rsp.hit_position = hit_position_reg;
    assign rsp.status       = status_reg;
    assign rsp.count        = count_out_reg;

endmodule

`default_nettype wire

// ----- rtl/isl_cell.sv -----
// One list cell: holds a word, shifts with its neighbours and flags matches.
`default_nettype none

module isl_cell (
    input  wire logic                   clk,
    input  wire logic [isl_pkg::IDX_W-1:0] idx,
    input  wire isl_pkg::cell_ctrl_t    ctrl,
    input  wire isl_pkg::word_t         left_word,
    input  wire isl_pkg::word_t         right_word,
    input  wire logic                   found_in,
    output isl_pkg::word_t              word,
    output logic                        found_out,
    output logic                        sel
);
    import isl_pkg::*;

    word_t            entry_reg;
    word_t            entry_next;
    logic             load;
    logic [CMP_W-1:0] my_pos;
    logic [CMP_W-1:0] my_pos_inc;
    logic             live;
    logic             match;

    assign my_pos     = CMP_W'(idx);
    assign my_pos_inc = my_pos + CMP_W'(1);
    assign live       = my_pos < ctrl.count;

    // Pick the next word: new value, left neighbour on insert, right on erase
    always_comb
    begin
        load       = 1'b0;
        entry_next = entry_reg;
        if (ctrl.shift_up)
        begin
            if (my_pos == ctrl.pos)
            begin
                load       = 1'b1;
                entry_next = ctrl.value;
            end
            else if ((my_pos > ctrl.pos) && (my_pos <= ctrl.count))
            begin
                load       = 1'b1;
                entry_next = left_word;
            end
        end
        else if (ctrl.shift_down)
        begin
            if ((my_pos >= ctrl.pos) && (my_pos_inc < ctrl.count))
            begin
                load       = 1'b1;
                entry_next = right_word;
            end
        end
    end

    // Hold the word; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_next;
        end
    end

    // Compare under the mask and pass the first-match flag along the row
    assign match     = live && (((entry_reg ^ ctrl.value) & ctrl.mask) == '0);
    assign found_out = found_in | match;
    assign sel       = ctrl.read_en ? (my_pos == ctrl.pos)
                                    : (ctrl.find_en && match && !found_in);
    assign word      = entry_reg;

endmodule

`default_nettype wire

// ----- rtl/isl_checker.sv -----
// Port-level checks on the indexed shift list and their bind to the top level.
`default_nettype none

module isl_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    input  wire logic                       req_ready,
    input  wire logic                       rsp_valid,
    input  wire logic                       rsp_ready,
    input  wire logic [isl_pkg::FIELD_W-1:0] rsp_read_word,
    input  wire logic                       rsp_hit,
    input  wire logic [isl_pkg::STATUS_W-1:0] rsp_status,
    input  wire logic [isl_pkg::COUNT_W-1:0]  rsp_count
);
    import isl_pkg::*;

    // A waiting response beat holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_word)
                                    && $stable(rsp_count) && $stable(rsp_status))
        else $error("response beat changed while stalled");

    // A request taken yields a response beat on the next cycle
    a_req_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request gave no response");

    // Fill count never exceeds the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_count <= COUNT_W'(DEPTH)))
        else $error("count beyond depth");

    // Full status only appears with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_W'(STATUS_FULL)) |-> (rsp_count == COUNT_W'(DEPTH)))
        else $error("full status with a list that is not full");

    // A hit always carries ok status
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> (rsp_status == STATUS_W'(STATUS_OK)))
        else $error("hit with error status");

endmodule

bind indexed_shift_list_top isl_checker u_isl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_word (rsp.read_word),
    .rsp_hit       (rsp.hit),
    .rsp_status    (rsp.status),
    .rsp_count     (rsp.count)
);

`default_nettype wire

// ----- test/isl_list_checker.sv -----
// Reply predictor and checker for the indexed shift list, watching both channels.
module isl_list_checker
    import isl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    isl_req_if                 req,
    isl_rsp_if                 rsp,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_wdata,
    output int                 mismatch_count,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] read_word;
        logic               hit;
        logic [POS_W-1:0]   hit_position;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } list_reply_t;

    word_t              list_words [DEPTH];
    int                 list_fill;
    logic [FIELD_W-1:0] find_mask;
    list_reply_t        expected_replies [$];
    list_reply_t        seen_reply;
    list_reply_t        predicted_reply;

    // Apply one request to the shadow list and return the reply it should give
    function automatic list_reply_t apply_request(kind_t k, logic [POS_W-1:0] p,
                                                  logic [FIELD_W-1:0] v);
        list_reply_t r;
        word_t       w;
        int          at;
        r = '0;
        r.status = STATUS_OK;
        w = word_t'(v);
        at = int'(p);
        case (k)
            KIND_INSERT:
            begin
                if (at > list_fill)
                    r.status = STATUS_RANGE;
                else if (list_fill >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    for (int i = list_fill; i > at; i--)
                        list_words[i] = list_words[i-1];
                    list_words[at] = w;
                    list_fill++;
                end
            end
            KIND_ERASE:
            begin
                if (at >= list_fill)
                    r.status = STATUS_RANGE;
                else
                begin
                    for (int i = at; i + 1 < list_fill; i++)
                        list_words[i] = list_words[i+1];
                    list_fill--;
                end
            end
            KIND_READ:
            begin
                if (at >= list_fill)
                    r.status = STATUS_RANGE;
                else
                    r.read_word = FIELD_W'(list_words[at]);
            end
            default:
            begin
                // first match wins, only masked bits take part
                for (int i = 0; i < list_fill; i++)
                begin
                    if (!r.hit && ((list_words[i] ^ w) & word_t'(find_mask)) == '0)
                    begin
                        r.hit = 1'b1;
                        r.hit_position = POS_W'(i);
                        r.read_word = FIELD_W'(list_words[i]);
                    end
                end
            end
        endcase
        r.count = COUNT_W'(list_fill);
        return r;
    endfunction

    // Compare a returned beat with the oldest prediction
    function automatic void check_reply(list_reply_t got);
        list_reply_t want;
        if (expected_replies.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: reply beat with no request waiting: %s %h %0d %0d %0d %0d",
                         $realtime, "word hit pos status count", got.read_word, got.hit,
                         got.hit_position, got.status, got.count);
            return;
        end
        want = expected_replies.pop_front();
        if (got.read_word !== want.read_word || got.hit !== want.hit
            || got.hit_position !== want.hit_position || got.status !== want.status
            || got.count !== want.count)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("%0t: reply mismatch", $realtime);
                $display("  expected word %h hit %0d pos %0d status %0d count %0d",
                         want.read_word, want.hit, want.hit_position, want.status, want.count);
                $display("  actual   word %h hit %0d pos %0d status %0d count %0d",
                         got.read_word, got.hit, got.hit_position, got.status, got.count);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_fill = 0;
            find_mask = '1;
            expected_replies.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            // check the returning beat first: it answers an earlier request
            if (rsp.valid && rsp.ready)
            begin
                seen_reply.read_word    = rsp.read_word;
                seen_reply.hit          = rsp.hit;
                seen_reply.hit_position = rsp.hit_position;
                seen_reply.status       = rsp.status;
                seen_reply.count        = rsp.count;
                check_reply(seen_reply);
            end
            if (cfg_we)
                find_mask = cfg_wdata;
            // predict the reply for a request beat taken at this edge
            if (req.valid && req.ready)
            begin
                predicted_reply  = apply_request(req.kind, req.position, req.value);
                expected_replies = {expected_replies, predicted_reply};
            end
            outstanding = expected_replies.size();
        end
    end

endmodule

// ----- test/indexed_shift_list_top_tb.sv -----
// Testbench top for the indexed shift list: clock, reset, stimulus, idling and verdict.
module indexed_shift_list_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isl_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int PHASES       = 4;
    localparam int TAIL_CYCLES  = 4;
    localparam int QUIET_LIMIT  = 2000;
    localparam int POOL_SIZE    = 24;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [FIELD_W-1:0] cfg_wdata;

    int                 mismatch_count;
    int                 outstanding;
    int                 quiet_cycles;

    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    int                 shadow_fill;
    bit                 growing;
    logic [FIELD_W-1:0] active_mask;
    logic [FIELD_W-1:0] word_pool [$];

    isl_req_if req_ch ();
    isl_rsp_if rsp_ch ();

    indexed_shift_list_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    isl_list_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Drop the response ready at random per the current stall rate
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // End the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one request beat, idling first at the sender rate, and hold until taken
    task automatic send_request(kind_t k, logic [POS_W-1:0] p, logic [FIELD_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.kind     = k;
        req_ch.position = p;
        req_ch.value    = v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // track the fill level to steer later positions
        if (k == KIND_INSERT && int'(p) <= shadow_fill && shadow_fill < DEPTH)
        begin
            shadow_fill++;
            word_pool = {word_pool, v};
            if (word_pool.size() > POOL_SIZE)
                void'(word_pool.pop_front());
        end
        else if (k == KIND_ERASE && int'(p) < shadow_fill)
            shadow_fill--;
    endtask

    // Release the channel and wait until every reply has returned
    task automatic drain_replies();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_compare_mask(logic [FIELD_W-1:0] m);
        drain_replies();
        cfg_we      = 1'b1;
        cfg_wdata   = m;
        active_mask = m;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Edge cases: empty list, position past the count, front and back, full list
    task automatic run_directed();
        send_request(KIND_FIND,   4'd0, 32'h0000_0000);
        send_request(KIND_READ,   4'd0, 32'h0000_0000);
        send_request(KIND_ERASE,  4'd0, 32'h0000_0000);
        send_request(KIND_INSERT, 4'd1, 32'h1111_1111);
        send_request(KIND_INSERT, 4'd0, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 4'd1, 32'h0000_0000);
        send_request(KIND_INSERT, 4'd0, 32'h8000_0001);
        send_request(KIND_INSERT, 4'd1, 32'h1234_5678);
        send_request(KIND_FIND,   4'd0, 32'h1234_5678);
        send_request(KIND_FIND,   4'd15, 32'hDEAD_BEEF);
        send_request(KIND_ERASE,  4'd0, 32'h0000_0000);
        send_request(KIND_ERASE,  4'd2, 32'h0000_0000);
        send_request(KIND_ERASE,  4'd5, 32'h0000_0000);
        // push at the back until the list is full
        while (shadow_fill < DEPTH)
            send_request(KIND_INSERT, POS_W'(shadow_fill), $urandom());
        send_request(KIND_INSERT, 4'd15, 32'hA5A5_5A5A);
        send_request(KIND_READ,   4'd15, 32'h0000_0000);
        send_request(KIND_FIND,   4'd0, 32'hFFFF_FFFF);
        send_request(KIND_ERASE,  4'd15, 32'h0000_0000);
    endtask

    // One random request, mostly at legal positions, swinging the list between empty and full
    task automatic random_request();
        int                 roll;
        int                 pick;
        kind_t              k;
        logic [POS_W-1:0]   p;
        logic [FIELD_W-1:0] v;
        roll = $urandom_range(99);
        if (growing)
            k = (roll < 50) ? KIND_INSERT : (roll < 65) ? KIND_ERASE :
                (roll < 82) ? KIND_READ : KIND_FIND;
        else
            k = (roll < 15) ? KIND_INSERT : (roll < 62) ? KIND_ERASE :
                (roll < 80) ? KIND_READ : KIND_FIND;

        if ($urandom_range(99) < 12 || k == KIND_FIND)
            p = POS_W'($urandom_range(15));
        else if (k == KIND_INSERT)
            p = POS_W'($urandom_range((shadow_fill < DEPTH) ? shadow_fill : DEPTH - 1));
        else
            p = POS_W'((shadow_fill == 0) ? 0 : $urandom_range(shadow_fill - 1));

        roll = $urandom_range(99);
        pick = (k == KIND_FIND) ? 70 : 30;
        if (roll < 8)
            v = '0;
        else if (roll < 16)
            v = '1;
        else if (roll < 16 + pick && word_pool.size() > 0)
            v = word_pool[$urandom_range(word_pool.size() - 1)];
        else
            v = $urandom();
        // disturb only the bits the mask ignores, so the key should still match
        if (k == KIND_FIND && $urandom_range(1) == 1)
            v = v ^ ($urandom() & ~active_mask);

        send_request(k, p, v);

        if ((growing && shadow_fill == DEPTH) || (!growing && shadow_fill == 0))
        begin
            if ($urandom_range(3) == 0)
                growing = !growing;
        end
        else if ($urandom_range(39) == 0)
            growing = !growing;
    endtask

    initial
    begin
        int idle_table  [PHASES];
        int stall_table [PHASES];
        logic [FIELD_W-1:0] mask_table [PHASES];

        idle_table  = '{0, 74, 0, 28};
        stall_table = '{0, 0, 74, 28};
        mask_table = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'hFFFF_00FF};
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_INSERT;
        req_ch.position    = '0;
        req_ch.value       = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        shadow_fill        = 0;
        growing            = 1'b1;
        active_mask        = '1;

        // hold reset, then release away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_compare_mask(mask_table[ph]);
            sender_idle_pct    = idle_table[ph];
            receiver_stall_pct = stall_table[ph];
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                random_request();
        end

        drain_replies();
        if (mismatch_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/isl_pkg.sv
rtl/isl_if.sv
rtl/isl_cell.sv
rtl/indexed_shift_list_top.sv
rtl/isl_checker.sv
test/isl_list_checker.sv
test/indexed_shift_list_top_tb.sv
